>>> rtl/kli_pkg.sv
// Package: types and constants shared by the keyframe interpolator modules.
`default_nettype none
package kli_pkg;

  localparam int unsigned KeyW = 15;
  localparam int unsigned ValW = 16;
  localparam int unsigned RgbW = 18;
  localparam int unsigned CoefW = 19;

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_GAIN_R = 2'd1,
    CFG_GAIN_G = 2'd2,
    CFG_GAIN_B = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  // Rec.709 XYZ to RGB, signed Q3.16, row-major
  typedef logic signed [CoefW-1:0] coef_t;

  function automatic coef_t mat_coef(input logic [1:0] row, input logic [1:0] col);
    coef_t c;
    c = '0;
    unique case ({row, col})
      4'b0000: c = 19'sd212368;
      4'b0001: c = -19'sd100739;
      4'b0010: c = -19'sd32672;
      4'b0100: c = -19'sd63521;
      4'b0101: c = 19'sd122945;
      4'b0110: c = 19'sd2723;
      4'b1000: c = 19'sd3647;
      4'b1001: c = -19'sd13372;
      4'b1010: c = 19'sd69292;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Queued query job: time only
  typedef struct packed {
    logic [KeyW-1:0] qtime;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/kli_queue.sv
// Two-entry queue between front and back ends.
`default_nettype none
module kli_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire kli_pkg::job_t   push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output kli_pkg::job_t        pop_data_o,
  output logic                 empty_o
);
  kli_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

>>> rtl/kli_back.sv
// Back end: key search, serial divide, matrix and gain per query.
`default_nettype none
module kli_back #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned FRAC_BITS = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // table write
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0] wr_idx_i,
  input  wire logic [kli_pkg::KeyW-1:0]     wr_key_i,
  input  wire logic [3*kli_pkg::ValW-1:0]   wr_val_i,
  input  wire logic [6:0]                   count_i,
  input  wire logic [15:0]                  gain_r_i,
  input  wire logic [15:0]                  gain_g_i,
  input  wire logic [15:0]                  gain_b_i,
  // job
  input  wire logic                         job_valid_i,
  input  wire kli_pkg::job_t                job_i,
  output logic                              job_pop_o,
  output logic                              busy_o,
  // result
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [kli_pkg::ValW-1:0]          lum_x_o,
  output logic [kli_pkg::ValW-1:0]          lum_y_o,
  output logic [kli_pkg::ValW-1:0]          lum_z_o,
  output logic signed [kli_pkg::RgbW-1:0]   rgb_red_o,
  output logic signed [kli_pkg::RgbW-1:0]   rgb_green_o,
  output logic signed [kli_pkg::RgbW-1:0]   rgb_blue_o
);
  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned KW = kli_pkg::KeyW;
  localparam int unsigned VW = kli_pkg::ValW;
  localparam int unsigned NW = VW + KW + 1;     // numerator width
  localparam int unsigned SH = 16 + FRAC_BITS;
  localparam int unsigned PW = 16 + 19 + 2 + 16 + 1; // sum times gain

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_RL, ST_LO, ST_MUL, ST_DIV, ST_NEXT, ST_MAT, ST_MACC,
    ST_GAIN, ST_OUT
  } st_e;

  logic [KW-1:0]   key_mem [MAX_ENTRIES];
  logic [3*VW-1:0] val_mem [MAX_ENTRIES];

  st_e             st_q, st_d;
  logic [KW-1:0]   t_q;
  logic [CW-1:0]   n_q, c_q;
  logic [IW-1:0]   ra_q;
  logic [KW-1:0]   krd_q;
  logic [3*VW-1:0] vrd_q;
  logic [KW-1:0]   kup_q, gap_q, dt_q;
  logic [3*VW-1:0] vup_q, vlo_q;
  logic [1:0]      ch_q, col_q;
  logic [NW-1:0]   rem_q;      // running remainder
  logic [NW-1:0]   num_q;      // dividend shifting out
  logic [VW-1:0]   quo_q;
  logic [5:0]      bit_q;
  logic [3*VW-1:0] lum_q;
  logic signed [37:0] acc_q;
  logic signed [37:0] prod_q;
  logic signed [PW-1:0] gp_q;
  logic            mulph_q;
  logic signed [3*kli_pkg::RgbW-1:0] rgb_q;
  logic            ov_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_idx_i] <= wr_key_i;
      val_mem[wr_idx_i] <= wr_val_i;
    end
    krd_q <= key_mem[ra_q];
    vrd_q <= val_mem[ra_q];
  end

  logic [15:0] gain_sel;
  always_comb begin
    case (ch_q)
      2'd0: gain_sel = gain_r_i;
      2'd1: gain_sel = gain_g_i;
      default: gain_sel = gain_b_i;
    endcase
  end

  logic [VW-1:0] vl_c, vu_c;
  assign vl_c = vlo_q[ch_q*VW +: VW];
  assign vu_c = vup_q[ch_q*VW +: VW];

  // restoring divide step
  logic [NW:0] trial;
  assign trial = {rem_q, num_q[NW-1]} - {{(NW+1-KW){1'b0}}, gap_q};

  // round and saturate the gain product
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shr;
  logic signed [kli_pkg::RgbW-1:0] sat;
  always_comb begin
    rnd = gp_q + (PW'(1) <<< (SH - 1));
    shr = rnd >>> SH;
    if (shr > PW'(131071)) sat = 18'sh1FFFF;
    else if (shr < -PW'(131072)) sat = 18'sh20000;
    else sat = shr[kli_pkg::RgbW-1:0];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (job_valid_i && !ov_q) st_d = ST_RD;
      ST_RD:   st_d = ST_CMP;
      ST_CMP: begin
        // end values skip the divide
        if (n_q == '0) st_d = ST_MAT;
        else if (krd_q > t_q) st_d = (c_q == '0) ? ST_MAT : ST_RL;
        else if (c_q + 1'b1 == n_q) st_d = ST_MAT;
        else st_d = ST_RD;
      end
      ST_RL:   st_d = ST_LO;
      ST_LO:   st_d = ST_MUL;
      ST_MUL:  st_d = mulph_q ? ST_DIV : ST_MUL;
      ST_DIV:  st_d = (bit_q == '0) ? ST_NEXT : ST_DIV;
      ST_NEXT: st_d = (ch_q == 2'd2) ? ST_MAT : ST_MUL;
      ST_MAT:  st_d = ST_MACC;
      ST_MACC: st_d = (col_q == 2'd2) ? ST_GAIN : ST_MACC;
      ST_GAIN: st_d = mulph_q ? ((ch_q == 2'd2) ? ST_OUT : ST_MAT) : ST_GAIN;
      ST_OUT:  st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign job_pop_o = (st_q == ST_IDLE) && job_valid_i && !ov_q;
  assign busy_o = (st_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_OUT) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  logic special_q; // hold end value, no interpolation

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        t_q <= job_i.qtime;
        n_q <= (32'(count_i) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(count_i);
        c_q <= '0;
        ra_q <= '0;
        lum_q <= '0;
      end
      ST_RD: ;
      ST_CMP: begin
        if (n_q != '0) begin
          if (krd_q > t_q) begin
            kup_q <= krd_q;
            vup_q <= vrd_q;
            special_q <= (c_q == '0);
            ra_q <= (c_q == '0) ? '0 : IW'(c_q - 1'b1);
            if (c_q == '0) lum_q <= vrd_q;
          end else if (c_q + 1'b1 == n_q) begin
            special_q <= 1'b1;
            lum_q <= vrd_q;
            c_q <= n_q;
          end else begin
            c_q <= c_q + 1'b1;
            ra_q <= IW'(c_q + 1'b1);
          end
        end
        ch_q <= '0;
        mulph_q <= 1'b0;
      end
      ST_RL: ;
      ST_LO: begin
        // krd/vrd now hold the lower entry, read during ST_RL
        vlo_q <= vrd_q;
        gap_q <= kup_q - krd_q;
        dt_q <= t_q - krd_q;
        ch_q <= '0;
        mulph_q <= 1'b0;
      end
      ST_MUL: begin
        if (!mulph_q) begin
          num_q <= NW'(vl_c * (gap_q - dt_q));
          mulph_q <= 1'b1;
        end else begin
          num_q <= num_q + NW'(vu_c * dt_q) + NW'(gap_q >> 1);
          rem_q <= '0;
          bit_q <= 6'(NW - 1);
          quo_q <= '0;
          mulph_q <= 1'b0;
        end
      end
      ST_DIV: begin
        if (!trial[NW]) begin
          rem_q <= trial[NW-1:0];
          quo_q <= {quo_q[VW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
          quo_q <= {quo_q[VW-2:0], 1'b0};
        end
        num_q <= {num_q[NW-2:0], 1'b0};
        bit_q <= bit_q - 1'b1;
      end
      ST_NEXT: begin
        if (!special_q) lum_q[ch_q*VW +: VW] <= quo_q;
        ch_q <= (ch_q == 2'd2) ? 2'd0 : ch_q + 1'b1;
      end
      ST_MAT: begin
        acc_q <= '0;
        col_q <= '0;
        prod_q <= 38'(kli_pkg::mat_coef(ch_q, 2'd0) * $signed({1'b0, lum_q[VW-1:0]}));
        mulph_q <= 1'b0;
      end
      ST_MACC: begin
        acc_q <= acc_q + prod_q;
        prod_q <= 38'(kli_pkg::mat_coef(ch_q, col_q + 1'b1)
                  * $signed({1'b0, lum_q[(col_q+1'b1)*VW +: VW]}));
        col_q <= col_q + 1'b1;
        if (col_q == 2'd2) col_q <= '0;
      end
      ST_GAIN: begin
        if (!mulph_q) begin
          gp_q <= PW'(acc_q * $signed({1'b0, gain_sel}));
          mulph_q <= 1'b1;
        end else begin
          rgb_q[ch_q*kli_pkg::RgbW +: kli_pkg::RgbW] <= sat;
          ch_q <= ch_q + 1'b1;
          mulph_q <= 1'b0;
        end
      end
      ST_OUT: begin
        lum_x_o <= lum_q[VW-1:0];
        lum_y_o <= lum_q[2*VW-1:VW];
        lum_z_o <= lum_q[3*VW-1:2*VW];
        rgb_red_o <= rgb_q[kli_pkg::RgbW-1:0];
        rgb_green_o <= rgb_q[2*kli_pkg::RgbW-1:kli_pkg::RgbW];
        rgb_blue_o <= rgb_q[3*kli_pkg::RgbW-1:2*kli_pkg::RgbW];
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

>>> rtl/keyframe_luminance_interpolator.sv
// Top level: config registers, front end classifier, queue and back end.
//
//  channel | handshake        | payload
//  in      | in_valid/stall   | req_type..query_time
//  out     | out_valid/stall  | lum_x..rgb_blue
//  cfg     | cfg_valid/ready  | cfg_index, cfg_data
//
// An interpolated query is popped, searches the keys for the first one above the
// time, fetches the lower entry, runs a bit-serial divide per channel, then the
// matrix and gain, and loads the result. End values and an empty table skip the
// divide. Reset clears the count to 0 and gains to unity. A stalled result holds
// the back end; queries queue two deep, and a table write waits until the queue
// and back end are idle.
`default_nettype none
module keyframe_luminance_interpolator #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned FRAC_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                req_type_i,
  input  wire logic [4:0]          entry_index_i,
  input  wire logic [14:0]         key_time_i,
  input  wire logic [15:0]         value_x_i,
  input  wire logic [15:0]         value_y_i,
  input  wire logic [15:0]         value_z_i,
  input  wire logic [14:0]         query_time_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [15:0]              lum_x_o,
  output logic [15:0]              lum_y_o,
  output logic [15:0]              lum_z_o,
  output logic signed [17:0]       rgb_red_o,
  output logic signed [17:0]       rgb_green_o,
  output logic signed [17:0]       rgb_blue_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  localparam int unsigned IW = $clog2(MAX_ENTRIES);

  logic [5:0]  count_q;
  logic [15:0] gain_r_q, gain_g_q, gain_b_q;
  logic        q_full, q_empty, q_pop, q_push, wr_en, back_busy;
  kli_pkg::job_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      gain_r_q <= 16'd1024;
      gain_g_q <= 16'd1024;
      gain_b_q <= 16'd1024;
    end else if (cfg_valid_i) begin
      unique case (kli_pkg::cfg_idx_e'(cfg_index_i))
        kli_pkg::CFG_COUNT:  count_q <= cfg_data_i[5:0];
        kli_pkg::CFG_GAIN_R: gain_r_q <= cfg_data_i;
        kli_pkg::CFG_GAIN_G: gain_g_q <= cfg_data_i;
        kli_pkg::CFG_GAIN_B: gain_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end: writes go to the table, queries to the queue
  logic is_query;
  assign is_query = (kli_pkg::req_e'(req_type_i) == kli_pkg::REQ_QUERY);
  // a write must not overtake a query still waiting or in progress
  assign in_stall_o = q_full || (!is_query && (!q_empty || back_busy));
  assign q_push = in_valid_i && !in_stall_o && is_query;
  assign wr_en = in_valid_i && !in_stall_o && !is_query
                 && (32'(entry_index_i) < MAX_ENTRIES);
  assign q_in.qtime = query_time_i;

  kli_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .pop_data_o(q_out), .empty_o(q_empty)
  );

  kli_back #(.MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_idx_i(IW'(entry_index_i)), .wr_key_i(key_time_i),
    .wr_val_i({value_z_i, value_y_i, value_x_i}),
    .count_i({1'b0, count_q}),
    .gain_r_i(gain_r_q), .gain_g_i(gain_g_q), .gain_b_i(gain_b_q),
    .job_valid_i(!q_empty), .job_i(q_out), .job_pop_o(q_pop), .busy_o(back_busy),
    .out_valid_o, .out_stall_i,
    .lum_x_o, .lum_y_o, .lum_z_o, .rgb_red_o, .rgb_green_o, .rgb_blue_o
  );

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("push into full queue");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(lum_x_o)))
    else $error("result lost under stall");
`endif
endmodule
`default_nettype wire

>>> bench/keyframe_luminance_interpolator_tb.sv
// Testbench: keyframe table load, time queries and XYZ-to-RGB conversion check.
`default_nettype none
module keyframe_luminance_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS     = 32;
  localparam int unsigned TIME_MAX  = 24576;
  localparam int unsigned SETTLE    = 300;

  typedef struct {
    kli_pkg::req_e kind;
    logic [4:0]  slot;
    logic [14:0] key;
    logic [15:0] vx, vy, vz;
    logic [14:0] qtime;
  } beat_t;

  typedef struct {
    logic [15:0]        lx, ly, lz;
    logic signed [17:0] r, g, b;
  } colour_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [4:0]         entry_index_i = '0;
  logic [14:0]        key_time_i = '0;
  logic [15:0]        value_x_i = '0, value_y_i = '0, value_z_i = '0;
  logic [14:0]        query_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        lum_x_o, lum_y_o, lum_z_o;
  logic signed [17:0] rgb_red_o, rgb_green_o, rgb_blue_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  keyframe_luminance_interpolator dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  beat_t       pending_q[$];
  colour_t     colour_q[$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  // shadow of the table and registers
  logic [14:0] shadow_key[SLOTS];
  logic [15:0] shadow_val[SLOTS][3];
  int unsigned shadow_count = 0;
  int unsigned shadow_gain[3] = '{1024, 1024, 1024};

  const longint rec709[3][3] = '{
    '{ 212368, -100739, -32672},
    '{ -63521,  122945,   2723},
    '{   3647,  -13372,  69292}
  };

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic track_beat(input beat_t bt);
    int unsigned n, up, lo;
    longint unsigned lum[3], gap, dt, num;
    longint s, p;
    colour_t c;
    if (bt.kind == kli_pkg::REQ_WRITE) begin
      shadow_key[bt.slot] = bt.key;
      shadow_val[bt.slot] = '{bt.vx, bt.vy, bt.vz};
      return;
    end
    lum = '{0, 0, 0};
    n = shadow_count < SLOTS ? shadow_count : SLOTS;
    if (n > 0) begin
      up = n;
      for (int i = n - 1; i >= 0; i--)
        if (shadow_key[i] > bt.qtime) up = i;
      if (up == n || up == 0) begin
        lo = (up == 0) ? 0 : n - 1;
        for (int k = 0; k < 3; k++) lum[k] = shadow_val[lo][k];
      end else begin
        lo = up - 1;
        gap = shadow_key[up] - shadow_key[lo];
        dt = bt.qtime - shadow_key[lo];
        for (int k = 0; k < 3; k++) begin
          num = shadow_val[lo][k] * (gap - dt) + shadow_val[up][k] * dt;
          lum[k] = (num + gap / 2) / gap;
        end
      end
    end
    c.lx = lum[0][15:0]; c.ly = lum[1][15:0]; c.lz = lum[2][15:0];
    for (int k = 0; k < 3; k++) begin
      s = rec709[k][0] * longint'(lum[0]) + rec709[k][1] * longint'(lum[1])
        + rec709[k][2] * longint'(lum[2]);
      p = (s * longint'(shadow_gain[k]) + (longint'(1) << 25)) >>> 26;
      if (p > 131071) p = 131071;
      if (p < -131072) p = -131072;
      case (k)
        0: c.r = p[17:0];
        1: c.g = p[17:0];
        default: c.b = p[17:0];
      endcase
    end
    colour_q.push_back(c);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic  fire, offer;
    beat_t nxt;
    fire = in_valid_i && !in_stall_o;
    if (fire) begin
      track_beat(pending_q.pop_front());
    end
    if (in_valid_i && !fire) begin
      offer = 1'b1;
    end else begin
      offer = rst_ni && pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct;
    end
    in_valid_i <= offer;
    if (offer) begin
      nxt = pending_q[0];
      req_type_i <= nxt.kind;
      entry_index_i <= nxt.slot;
      key_time_i <= nxt.key;
      value_x_i <= nxt.vx;
      value_y_i <= nxt.vy;
      value_z_i <= nxt.vz;
      query_time_i <= nxt.qtime;
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_req != 0 && hold_left == 0) begin
      hold_left <= hold_req;
      hold_req <= 0;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    colour_t w;
    if (out_valid_o && !out_stall_i) begin
      if (colour_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = colour_q.pop_front();
        if (lum_x_o !== w.lx) report_mismatch("lum_x", lum_x_o, w.lx);
        if (lum_y_o !== w.ly) report_mismatch("lum_y", lum_y_o, w.ly);
        if (lum_z_o !== w.lz) report_mismatch("lum_z", lum_z_o, w.lz);
        if (rgb_red_o !== w.r) report_mismatch("rgb_red", rgb_red_o, w.r);
        if (rgb_green_o !== w.g) report_mismatch("rgb_green", rgb_green_o, w.g);
        if (rgb_blue_o !== w.b) report_mismatch("rgb_blue", rgb_blue_o, w.b);
      end
    end
  end

  task automatic write_reg(input kli_pkg::cfg_idx_e idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == kli_pkg::CFG_COUNT) shadow_count = data[5:0];
    else shadow_gain[idx - 1] = data;
  endtask

  task automatic push_entry(input int slot, input int key, input int x, input int y,
                            input int z);
    beat_t bt;
    bt = '{kli_pkg::REQ_WRITE, slot[4:0], key[14:0], x[15:0], y[15:0], z[15:0],
           15'($urandom)};
    pending_q.push_back(bt);
  endtask

  task automatic push_query(input int qt);
    beat_t bt;
    bt = '{kli_pkg::REQ_QUERY, 5'($urandom), 15'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), qt[14:0]};
    pending_q.push_back(bt);
  endtask

  // wait for the pipe to empty, then let any write settle
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || colour_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_table(input bit sorted);
    int k;
    k = $urandom_range(3000);
    for (int i = 0; i < SLOTS; i++) begin
      if (sorted) k = k + $urandom_range(1500) * ($urandom_range(9) != 0);
      else k = $urandom_range(TIME_MAX);
      if (k > TIME_MAX) k = TIME_MAX;
      push_entry(i, k, $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(65535));
    end
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int cnt, nq;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty table, ends, exact keys, mid points, gain extremes
    for (int i = 0; i < SLOTS; i++)
      push_entry(i, 1000 + 700 * i, (i % 2) ? 65535 : 0, 1024 * i, 65535 - 2000 * i);
    push_query(5000);
    drain();
    write_reg(kli_pkg::CFG_COUNT, 16'd32);
    push_query(0);
    push_query(1000);
    push_query(1350);
    push_query(1700);
    push_query(2049);
    push_query(1000 + 700 * 31);
    push_query(TIME_MAX);
    drain();
    write_reg(kli_pkg::CFG_GAIN_R, 16'hFFFF);
    write_reg(kli_pkg::CFG_GAIN_G, 16'd0);
    write_reg(kli_pkg::CFG_GAIN_B, 16'hFFFF);
    push_query(1400);
    push_query(2400);
    push_query(TIME_MAX);
    drain();
    write_reg(kli_pkg::CFG_COUNT, 16'd1);
    push_query(0);
    push_query(TIME_MAX);
    drain();
    write_reg(kli_pkg::CFG_COUNT, 16'd63);
    push_query(12000);
    drain();

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case ($urandom_range(5))
        0: cnt = 0;
        1: cnt = 32;
        2: cnt = 1;
        3: cnt = $urandom_range(63, 33);
        default: cnt = $urandom_range(31, 2);
      endcase
      write_reg(kli_pkg::CFG_COUNT, cnt[15:0]);
      write_reg(kli_pkg::CFG_GAIN_R, pick_gain());
      write_reg(kli_pkg::CFG_GAIN_G, pick_gain());
      write_reg(kli_pkg::CFG_GAIN_B, pick_gain());
      load_table(ph % 5 != 4);
      drain();
      if (ph == 6) hold_req = 3000;
      nq = 85 + $urandom_range(20);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(3) == 0) push_query(shadow_key[$urandom_range(SLOTS - 1)]);
        else push_query($urandom_range(TIME_MAX));
      end
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/kli_pkg.sv
rtl/kli_queue.sv
rtl/kli_back.sv
rtl/keyframe_luminance_interpolator.sv
bench/keyframe_luminance_interpolator_tb.sv
